/* rtl/ecn_pkg.sv */
// shared types and constants for the ecn congestion window engine
package ecn_pkg;

    localparam int ALPHA_FRAC_BITS = 16;

    localparam logic [2:0] OP_ACK      = 3'd0;
    localparam logic [2:0] OP_LOSS     = 3'd1;
    localparam logic [2:0] OP_CE       = 3'd2;
    localparam logic [2:0] OP_NO_CE    = 3'd3;
    localparam logic [2:0] OP_DELAYED  = 3'd4;
    localparam logic [2:0] OP_IMMED    = 3'd5;
    localparam logic [2:0] OP_SSTHRESH = 3'd6;

    localparam logic [2:0] CS_OPEN     = 3'd0;
    localparam logic [2:0] CS_CWR      = 3'd2;
    localparam logic [2:0] CS_RECOVERY = 3'd3;
    localparam logic [2:0] CS_LOSS     = 3'd4;

    localparam logic [1:0] ECN_NONE    = 2'd0;
    localparam logic [1:0] ECN_MARKED  = 2'd1;
    localparam logic [1:0] ECN_SENDING = 2'd2;

    localparam logic [1:0] REG_GAIN       = 2'd0;
    localparam logic [1:0] REG_ALPHA_INIT = 2'd1;
    localparam logic [1:0] REG_SEGMENT    = 2'd2;
    localparam logic [1:0] REG_MARGIN     = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  cong_state;
        logic [31:0] rtt_us;
        logic [31:0] srtt_us;
        logic [31:0] ce_bytes;
        logic [31:0] acked_bytes;
        logic [31:0] cwnd_in;
        logic [31:0] rcv_nxt;
        logic [1:0]  ecn_state;
        logic [31:0] bytes_in_flight;
    } in_item_t;

    typedef struct packed {
        logic [31:0] cwnd_out;
        logic [31:0] ssthresh_out;
        logic        ssthresh_written;
        logic        send_ack;
        logic [31:0] ack_seq;
        logic        ack_ece;
        logic [1:0]  ecn_state_out;
        logic        fallback_active;
        logic [16:0] alpha_q16;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

/* rtl/ecn_congestion_window_engine.sv */
// top level of the ecn congestion window engine
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, in_data      | request in
//  out     | out_valid, out_ready, out_data   | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index, | register write in
//          | cfg_data                         |
//
// an ack in open runs two serial divides (fraction, growth) and three serial multiplies
// plus control steps; no acked bytes skips the fraction divide, a state other than open
// skips the growth; a cwr loss runs one serial multiply before its result is formed
// all other requests go straight from accept to the finish and output states
// after reset the engine accepts at once; one request is worked at a time
// a result waits in the output register; the next request is taken while it waits
// and its work runs until it needs the output register
module ecn_congestion_window_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ecn_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ecn_pkg::out_item_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    localparam int F  = ecn_pkg::ALPHA_FRAC_BITS;
    localparam int AW = F + 1;
    localparam logic [AW-1:0] ONE = AW'(1) << F;
    localparam int NW = 32 + F;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FRAC  = 9'b000000010,
        S_EW1   = 9'b000000100,
        S_EW2   = 9'b000001000,
        S_GROW  = 9'b000010000,
        S_GDIV  = 9'b000100000,
        S_LMUL  = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [16:0] gain_reg;
    logic [15:0] seg_reg;
    logic [19:0] margin_reg;

    logic [AW-1:0] alpha_reg, alpha_next;
    logic [31:0]   base_reg, base_next;
    logic          fb_reg, fb_next, ce_reg, ce_next, dly_reg, dly_next;
    logic          pv_reg, pv_next;
    logic [31:0]   prior_reg, prior_next;

    ecn_pkg::in_item_t  it_reg, it_next;
    ecn_pkg::out_item_t res_reg, res_next;
    logic [AW-1:0] frac_reg, frac_next;
    logic [NW:0]   acc_reg, acc_next;
    logic          ov_reg, ov_next;

    logic            d_start;
    logic [NW-1:0]   d_num;
    logic [32:0]     d_den;
    logic [NW-1:0]   d_quo;
    ecn_pkg::unit_ctl_t d_ctl;
    logic            m_start;
    logic [31:0]     m_a;
    logic [32:0]     m_b;
    logic [64:0]     m_prod;
    ecn_pkg::unit_ctl_t m_ctl;

    ecn_serial_div #(.NW(NW), .DW(33)) u_div (
        .clk(clk), .rst_n(rst_n), .start(d_start), .num(d_num), .den(d_den),
        .quo(d_quo), .ctl(d_ctl)
    );

    ecn_serial_mul #(.AW(32), .BW(33)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
        .prod(m_prod), .ctl(m_ctl)
    );

    function automatic logic [AW-1:0] clamp17(input logic [16:0] v);
        logic [AW-1:0] r;
        begin
            if ({15'd0, v} > 32'(ONE))
                r = ONE;
            else
                r = AW'(v);
            return r;
        end
    endfunction

    function automatic logic [31:0] floor2(input logic [31:0] v, input logic [15:0] s);
        logic [31:0] f;
        begin
            f = {15'd0, s, 1'b0};
            return (v > f) ? v : f;
        end
    endfunction

    logic          out_free;
    logic [AW-1:0] g;

    assign out_free  = !out_valid || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign g         = clamp17(gain_reg);

    always_comb
    begin
        state_next = state_reg;
        alpha_next = alpha_reg;
        base_next  = base_reg;
        fb_next    = fb_reg;
        ce_next    = ce_reg;
        dly_next   = dly_reg;
        pv_next    = pv_reg;
        prior_next = prior_reg;
        it_next    = it_reg;
        res_next   = res_reg;
        frac_next  = frac_reg;
        acc_next   = acc_reg;
        ov_next    = ov_reg;
        d_start    = 1'b0;
        d_num      = '0;
        d_den      = '0;
        m_start    = 1'b0;
        m_a        = '0;
        m_b        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    it_next = in_data;
                    res_next = '0;
                    res_next.cwnd_out = in_data.cwnd_in;
                    res_next.ecn_state_out = in_data.ecn_state;
                    state_next = S_FIN;
                    case (in_data.op)
                        ecn_pkg::OP_ACK:
                        begin
                            if (in_data.cong_state != ecn_pkg::CS_RECOVERY &&
                                in_data.cong_state != ecn_pkg::CS_LOSS)
                            begin
                                if (in_data.rtt_us != '0)
                                begin
                                    if (base_reg == '0 || in_data.rtt_us < base_reg)
                                        base_next = in_data.rtt_us;
                                    // margin sum kept at 33 bits so it cannot wrap
                                    fb_next = {1'b0, in_data.srtt_us} >
                                              ({1'b0, base_next} + 33'(margin_reg));
                                end
                                state_next = S_FRAC;
                                d_start = (in_data.acked_bytes != '0);
                                d_num = {in_data.ce_bytes, F'(0)};
                                d_den = {1'b0, in_data.acked_bytes};
                                frac_next = '0;
                                if (in_data.acked_bytes == '0)
                                    state_next = S_EW1;
                            end
                        end
                        ecn_pkg::OP_LOSS:
                        begin
                            if (in_data.cong_state == ecn_pkg::CS_CWR)
                            begin
                                m_start = 1'b1;
                                m_a = in_data.cwnd_in;
                                m_b = 33'((34'(ONE) << 1) + 34'(alpha_reg));
                                state_next = S_LMUL;
                            end
                            else
                            begin
                                res_next.ssthresh_out = floor2({1'b0, in_data.cwnd_in[31:1]},
                                                               seg_reg);
                                res_next.ssthresh_written = 1'b1;
                                res_next.cwnd_out = res_next.ssthresh_out;
                            end
                        end
                        ecn_pkg::OP_CE:
                        begin
                            if (fb_reg)
                            begin
                                res_next.ssthresh_out = floor2({1'b0, in_data.cwnd_in[31:1]},
                                                               seg_reg);
                                res_next.ssthresh_written = 1'b1;
                                res_next.cwnd_out = res_next.ssthresh_out;
                            end
                            else
                            begin
                                if (!ce_reg && dly_reg && pv_reg)
                                begin
                                    res_next.send_ack = 1'b1;
                                    res_next.ack_seq = prior_reg;
                                end
                                pv_next = 1'b1;
                                prior_next = in_data.rcv_nxt;
                                ce_next = 1'b1;
                                res_next.ecn_state_out = ecn_pkg::ECN_MARKED;
                            end
                        end
                        ecn_pkg::OP_NO_CE:
                        begin
                            if (ce_reg && dly_reg && pv_reg)
                            begin
                                res_next.send_ack = 1'b1;
                                res_next.ack_seq = prior_reg;
                                res_next.ack_ece = 1'b1;
                            end
                            pv_next = 1'b1;
                            prior_next = in_data.rcv_nxt;
                            ce_next = 1'b0;
                            if (in_data.ecn_state == ecn_pkg::ECN_MARKED ||
                                in_data.ecn_state == ecn_pkg::ECN_SENDING)
                                res_next.ecn_state_out = ecn_pkg::ECN_NONE;
                        end
                        ecn_pkg::OP_DELAYED: dly_next = 1'b1;
                        ecn_pkg::OP_IMMED:   dly_next = 1'b0;
                        ecn_pkg::OP_SSTHRESH:
                        begin
                            res_next.ssthresh_out =
                                floor2({1'b0, in_data.bytes_in_flight[31:1]}, seg_reg);
                            res_next.ssthresh_written = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_FRAC:
            begin
                if (d_ctl.done)
                begin
                    frac_next = (d_quo > NW'(ONE)) ? ONE : AW'(d_quo);
                    state_next = S_EW1;
                end
            end
            S_EW1:
            begin
                // (one - g) * alpha
                m_start = 1'b1;
                m_a = 32'(ONE - g);
                m_b = 33'(alpha_reg);
                state_next = S_EW2;
                acc_next = '0;
            end
            S_EW2:
            begin
                if (m_ctl.done)
                begin
                    if (acc_reg == '0 && !ov_reg)
                    begin
                        acc_next = (NW+1)'(m_prod);
                        ov_next = 1'b1;
                        m_start = 1'b1;
                        m_a = 32'(g);
                        m_b = 33'(frac_reg);
                    end
                    else
                    begin
                        acc_next = acc_reg + (NW+1)'(m_prod);
                        ov_next = 1'b0;
                        state_next = S_GROW;
                    end
                end
            end
            S_GROW:
            begin
                alpha_next = ((acc_reg >> F) > (NW+1)'(ONE)) ? ONE : AW'(acc_reg >> F);
                res_next.cwnd_out = it_reg.cwnd_in;
                if (it_reg.cong_state == ecn_pkg::CS_OPEN)
                begin
                    m_start = 1'b1;
                    m_a = {16'd0, seg_reg};
                    m_b = {17'd0, seg_reg};
                    state_next = S_GDIV;
                end
                else
                    state_next = S_FIN;
            end
            S_GDIV:
            begin
                if (m_ctl.done)
                begin
                    d_start = 1'b1;
                    d_num = NW'(m_prod[31:0]);
                    d_den = (it_reg.cwnd_in == '0) ? 33'd1 : {1'b0, it_reg.cwnd_in};
                end
                else if (d_ctl.done)
                begin
                    acc_next = (NW+1)'(it_reg.cwnd_in) +
                               ((d_quo == '0) ? (NW+1)'(1) : (NW+1)'(d_quo));
                    res_next.cwnd_out = (acc_next > (NW+1)'(32'hFFFF_FFFF)) ?
                                        32'hFFFF_FFFF : acc_next[31:0];
                    state_next = S_FIN;
                end
            end
            S_LMUL:
            begin
                if (m_ctl.done)
                begin
                    res_next.ssthresh_out = floor2(m_prod[F+33:F+2], seg_reg);
                    res_next.ssthresh_written = 1'b1;
                    res_next.cwnd_out = res_next.ssthresh_out;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                res_next.fallback_active = fb_reg;
                res_next.alpha_q16 = 17'(alpha_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic out_valid_reg;
    ecn_pkg::out_item_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            gain_reg   <= 17'd4096;
            seg_reg    <= 16'd1448;
            margin_reg <= 20'd3000;
            alpha_reg  <= clamp17(17'd65536);
            base_reg   <= '0;
            fb_reg     <= 1'b0;
            ce_reg     <= 1'b0;
            dly_reg    <= 1'b0;
            pv_reg     <= 1'b0;
            prior_reg  <= '0;
            ov_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            alpha_reg <= alpha_next;
            base_reg  <= base_next;
            fb_reg    <= fb_next;
            ce_reg    <= ce_next;
            dly_reg   <= dly_next;
            pv_reg    <= pv_next;
            prior_reg <= prior_next;
            ov_reg    <= ov_next;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ecn_pkg::REG_GAIN:       gain_reg   <= cfg_data[16:0];
                    // alpha init writes are ignored; reset restores the alpha default
                    ecn_pkg::REG_ALPHA_INIT: ;
                    ecn_pkg::REG_SEGMENT:    seg_reg    <= cfg_data[15:0];
                    ecn_pkg::REG_MARGIN:     margin_reg <= cfg_data[19:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        res_reg  <= res_next;
        frac_reg <= frac_next;
        acc_reg  <= acc_next;
        if (state_reg == S_OUT && out_free)
            out_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        alpha_reg <= ONE)
        else $error("alpha above one");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> out_valid)
        else $error("result not presented");
    a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(d_ctl.busy && m_ctl.busy))
        else $error("divider and multiplier both busy");
endmodule

/* rtl/ecn_serial_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module ecn_serial_div #(
    parameter int NW = 64,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output ecn_pkg::unit_ctl_t ctl
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quo       = q_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule

/* rtl/ecn_serial_mul.sv */
// shift-and-add multiplier, one multiplier bit per cycle
module ecn_serial_mul #(
    parameter int AW = 32,
    parameter int BW = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic [AW+BW-1:0] prod,
    output ecn_pkg::unit_ctl_t ctl
);
    localparam int CW = $clog2(BW + 1);

    logic [AW+BW-1:0] p_reg, p_next;
    logic [AW-1:0]    a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [AW:0]      hi;

    always_comb
    begin
        p_next    = p_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        hi        = {1'b0, p_reg[AW+BW-1:BW]} + (b_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            p_next    = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // add the partial product on top, then shift right one place
            p_next   = {hi, p_reg[BW-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign prod      = p_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
endmodule
